// ===== src/nbte_pkg.sv =====
package nbte_pkg;

  // Table sizes
  localparam int RULE_SLOTS    = 16;
  localparam int BINDING_SLOTS = 256;

  localparam int RA_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int RI_W = $clog2(RULE_SLOTS + 1);
  localparam int BA_W = (BINDING_SLOTS > 1) ? $clog2(BINDING_SLOTS) : 1;
  localparam int BC_W = $clog2(BINDING_SLOTS + 1);

  // Port-use bitmap: one 16-bit word per kind and port group
  localparam int PW_W   = 13;
  localparam int PWORDS = 8192;

  // Commands
  localparam logic [1:0] CMD_XLAT = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_DEL  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_EXIST  = 3'd0;
  localparam logic [2:0] ST_NEW    = 3'd1;
  localparam logic [2:0] ST_NORULE = 3'd2;
  localparam logic [2:0] ST_RANGE  = 3'd3;
  localparam logic [2:0] ST_NOTAG  = 3'd4;
  localparam logic [2:0] ST_FULL   = 3'd5;

  typedef enum logic [2:0] {
    T_IDLE, T_BSCAN, T_RSCAN, T_ALLOC_GO, T_ALLOC, T_ADD, T_DUPD, T_FIN
  } eng_state_t;

  typedef enum logic [2:0] {
    A_CLR, A_IDLE, A_RD, A_CHK, A_ZRD, A_ZWR
  } alloc_state_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] mask;
    logic [31:0] dest;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [7:0]  tag;
    logic        kind;
  } rule_ent_t;

  typedef struct packed {
    logic [48:0] key;
    logic [47:0] map;
  } bind_ent_t;

  typedef struct packed {
    logic        start;
    logic        kind;
    logic [15:0] lo;
    logic [15:0] hi;
  } alloc_req_t;

  typedef struct packed {
    logic        ready;
    logic        done;
    logic [15:0] port;
  } alloc_rsp_t;

endpackage

// ===== src/nbte_port_alloc.sv =====
module nbte_port_alloc
  import nbte_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  alloc_req_t req,
  output alloc_rsp_t rsp
);

  alloc_state_t state_r, state_nxt;

  logic [PW_W-1:0] clr_r;
  logic            kind_r;
  logic [11:0]     word_r;
  logic [3:0]      start_r;
  logic [15:0]     hi_r;

  logic [15:0] pmem [PWORDS];
  logic [15:0] pmem_q;

  logic [PW_W-1:0] rd_addr;
  logic            wr_en;
  logic [PW_W-1:0] wr_addr;
  logic [15:0]     wr_data;

  logic [15:0] lo_mask, hi_mask, avail;
  logic [3:0]  enc;
  logic        any_free;

  // Free bits of the current word inside the search window
  always_comb begin
    lo_mask = 16'hFFFF << start_r;
    hi_mask = (word_r == hi_r[15:4]) ? (16'hFFFF >> (4'd15 - hi_r[3:0])) : 16'hFFFF;
    avail   = ~pmem_q & lo_mask & hi_mask;
    any_free = |avail;
    enc = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (avail[i]) enc = 4'(i);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      A_CLR:  if (clr_r == PW_W'(PWORDS - 1)) state_nxt = A_IDLE;
      A_IDLE: if (req.start) state_nxt = A_RD;
      A_RD:   state_nxt = A_CHK;
      A_CHK: begin
        if (any_free) state_nxt = A_IDLE;
        else if (word_r == hi_r[15:4]) state_nxt = A_ZRD;
        else state_nxt = A_RD;
      end
      A_ZRD:  state_nxt = A_ZWR;
      A_ZWR:  state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  // Outputs and bitmap access
  always_comb begin
    rd_addr   = {kind_r, word_r};
    wr_en     = 1'b0;
    wr_addr   = {kind_r, word_r};
    wr_data   = pmem_q;
    rsp.ready = 1'b1;
    rsp.done  = 1'b0;
    rsp.port  = {word_r, enc};
    unique case (state_r)
      A_CLR: begin
        rsp.ready = 1'b0;
        wr_en     = 1'b1;
        wr_addr   = clr_r;
        wr_data   = 16'h0000;
      end
      A_CHK: begin
        if (any_free) begin
          wr_en    = 1'b1;
          wr_data  = pmem_q | (16'h0001 << enc);
          rsp.done = 1'b1;
        end
      end
      A_ZRD: rd_addr = {kind_r, 12'h000};
      A_ZWR: begin
        wr_en    = 1'b1;
        wr_addr  = {kind_r, 12'h000};
        wr_data  = pmem_q | 16'h0001;
        rsp.done = 1'b1;
        rsp.port = 16'h0000;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_CLR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == A_CLR) clr_r <= clr_r + PW_W'(1);
    end
  end

  // Hold the search window and advance word by word
  always_ff @(posedge clk) begin
    if (state_r == A_IDLE && req.start) begin
      kind_r  <= req.kind;
      word_r  <= req.lo[15:4];
      start_r <= req.lo[3:0];
      hi_r    <= req.hi;
    end else if (state_r == A_CHK && !any_free && word_r != hi_r[15:4]) begin
      word_r  <= word_r + 12'd1;
      start_r <= 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) pmem[wr_addr] <= wr_data;
    pmem_q <= pmem[rd_addr];
  end

endmodule

// ===== src/nat_binding_table_engine.sv =====
// Flow: a translate of a known flow searches the bindings; a new binding adds a rule walk
// and a port-bitmap scan word by word (up to 4096 words, plus a read and write of word 0
// when the range is exhausted). Add writes the rule directly; delete walks the rules first. One request is
// in flight at a time; the next is taken once the result is loaded into the output register.
// Reset: synchronous active-low rst_n empties both tables, then a clearing pass zeroes all
// 8192 port-bitmap words; in_tready stays low during that pass.
module nat_binding_table_engine
  import nbte_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // src_addr, src_port, peer_addr, rule_mask, rule_target, rule_min_port,
  // rule_max_port, rule_tag
  input  logic [183:0] in_tdata,
  // cmd, xlat_kind
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, mapped_addr, mapped_port, zero pad
  output logic [55:0]  out_tdata
);

  eng_state_t state_r, state_nxt;

  // Captured request
  logic [1:0]  cmd_r;
  logic        kind_r;
  logic [31:0] src_r, peer_r, mask_r, tgt_r;
  logic [15:0] sport_r, lo_r, hi_r;
  logic [7:0]  tag_r;

  // Rule bookkeeping in flops
  logic           rvalid_r [RULE_SLOTS];
  logic [RA_W-1:0] rage_r  [RULE_SLOTS];
  logic [BC_W-1:0] bind_cnt_r;

  // Scan control
  logic [BC_W-1:0] bi_r;
  logic [RI_W-1:0] ri_r;
  logic            pend_r;
  logic [RA_W-1:0] pidx_r;
  logic            found_r;
  logic [RA_W-1:0] best_idx_r, best_age_r;
  logic [31:0]     bdest_r;
  logic [15:0]     blo_r, bhi_r;

  // Result
  logic [2:0]  res_status_r;
  logic [31:0] res_addr_r;
  logic [15:0] res_port_r;
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_addr_r;
  logic [15:0] out_port_r;

  // Memories
  rule_ent_t rmem [RULE_SLOTS];
  rule_ent_t rmem_q;
  bind_ent_t bmem [BINDING_SLOTS];
  bind_ent_t bmem_q;

  alloc_req_t alloc_req;
  alloc_rsp_t alloc_rsp;

  logic            accept;
  logic [48:0]     key;
  logic            b_issue, b_hit, b_end;
  logic            r_issue, r_match, r_better, r_end;
  logic [31:0]     msrc;
  logic            free_any;
  logic [RA_W-1:0] free_idx;

  nbte_port_alloc u_alloc (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (alloc_req),
    .rsp  (alloc_rsp)
  );

  assign accept     = in_tvalid && in_tready;
  assign key        = {src_r, sport_r, kind_r};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_port_r, out_addr_r, out_status_r};

  // Binding walk compare
  assign b_issue = bi_r < bind_cnt_r;
  assign b_hit   = pend_r && (bmem_q.key == key);
  assign b_end   = !b_issue && !pend_r;

  // Rule walk compare
  always_comb begin
    msrc    = rmem_q.src & rmem_q.mask;
    r_issue = ri_r < RI_W'(RULE_SLOTS);
    if (cmd_r == CMD_DEL) begin
      r_match = rvalid_r[pidx_r] && (rmem_q.tag == tag_r);
    end else begin
      r_match = rvalid_r[pidx_r] && (rmem_q.kind == kind_r) &&
                ((src_r & rmem_q.mask) == msrc) && ((peer_r & rmem_q.mask) != msrc) &&
                (peer_r != rmem_q.dest);
    end
    r_better = pend_r && r_match && (!found_r || rage_r[pidx_r] < best_age_r);
    r_end    = !r_issue && !pend_r;
  end

  // Lowest free rule slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = RULE_SLOTS - 1; i >= 0; i--) begin
      if (!rvalid_r[i]) begin
        free_any = 1'b1;
        free_idx = RA_W'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: begin
        if (accept) begin
          case (in_tuser[1:0])
            CMD_XLAT: state_nxt = T_BSCAN;
            CMD_ADD:  state_nxt = T_ADD;
            CMD_DEL:  state_nxt = T_RSCAN;
            default:  state_nxt = T_FIN;
          endcase
        end
      end
      T_BSCAN: begin
        if (b_hit) state_nxt = T_FIN;
        else if (b_end) state_nxt = T_RSCAN;
      end
      T_RSCAN: begin
        if (r_end) begin
          if (!found_r) state_nxt = T_FIN;
          else if (cmd_r == CMD_DEL) state_nxt = T_DUPD;
          else if (bind_cnt_r >= BC_W'(BINDING_SLOTS)) state_nxt = T_FIN;
          else state_nxt = T_ALLOC_GO;
        end
      end
      T_ALLOC_GO: state_nxt = T_ALLOC;
      T_ALLOC:    if (alloc_rsp.done) state_nxt = T_FIN;
      T_ADD:      state_nxt = T_FIN;
      T_DUPD:     state_nxt = T_FIN;
      T_FIN:      if (!out_valid_r || out_tready) state_nxt = T_IDLE;
      default:    state_nxt = T_IDLE;
    endcase
  end

  // Handshake and allocator request
  always_comb begin
    in_tready       = (state_r == T_IDLE) && alloc_rsp.ready;
    alloc_req.start = (state_r == T_ALLOC_GO);
    alloc_req.kind  = kind_r;
    alloc_req.lo    = blo_r;
    alloc_req.hi    = bhi_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= T_IDLE;
    else state_r <= state_nxt;
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_tuser[1:0];
      kind_r  <= in_tuser[2];
      src_r   <= in_tdata[31:0];
      sport_r <= in_tdata[47:32];
      peer_r  <= in_tdata[79:48];
      mask_r  <= in_tdata[111:80];
      tgt_r   <= in_tdata[143:112];
      lo_r    <= in_tdata[159:144];
      hi_r    <= in_tdata[175:160];
      tag_r   <= in_tdata[183:176];
    end
  end

  // Walk counters and best-rule tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      case (state_r)
        T_IDLE: begin
          bi_r    <= '0;
          ri_r    <= '0;
          pend_r  <= 1'b0;
          found_r <= 1'b0;
        end
        T_BSCAN: begin
          bi_r   <= bi_r + BC_W'(b_issue);
          pend_r <= b_issue;
        end
        T_RSCAN: begin
          ri_r   <= ri_r + RI_W'(r_issue);
          pend_r <= r_issue;
          pidx_r <= ri_r[RA_W-1:0];
          if (r_better) begin
            found_r    <= 1'b1;
            best_idx_r <= pidx_r;
            best_age_r <= rage_r[pidx_r];
            bdest_r    <= rmem_q.dest;
            blo_r      <= rmem_q.lo;
            bhi_r      <= rmem_q.hi;
          end
        end
        default: ;
      endcase
    end
  end

  // Rule valid bits and ages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RULE_SLOTS; i++) begin
        rvalid_r[i] <= 1'b0;
        rage_r[i]   <= '0;
      end
    end else if (state_r == T_ADD && lo_r <= hi_r && free_any) begin
      for (int i = 0; i < RULE_SLOTS; i++) begin
        if (rvalid_r[i]) rage_r[i] <= rage_r[i] + RA_W'(1);
      end
      rvalid_r[free_idx] <= 1'b1;
      rage_r[free_idx]   <= '0;
    end else if (state_r == T_DUPD) begin
      for (int i = 0; i < RULE_SLOTS; i++) begin
        if (rvalid_r[i] && rage_r[i] > best_age_r) rage_r[i] <= rage_r[i] - RA_W'(1);
      end
      rvalid_r[best_idx_r] <= 1'b0;
      rage_r[best_idx_r]   <= '0;
    end
  end

  // Binding count
  always_ff @(posedge clk) begin
    if (!rst_n) bind_cnt_r <= '0;
    else if (state_r == T_ALLOC && alloc_rsp.done) bind_cnt_r <= bind_cnt_r + BC_W'(1);
  end

  // Rule memory
  always_ff @(posedge clk) begin
    if (state_r == T_ADD && lo_r <= hi_r && free_any) begin
      rmem[free_idx] <= '{src: src_r, mask: mask_r, dest: tgt_r, lo: lo_r, hi: hi_r,
                          tag: tag_r, kind: kind_r};
    end
    rmem_q <= rmem[ri_r[RA_W-1:0]];
  end

  // Binding memory
  always_ff @(posedge clk) begin
    if (state_r == T_ALLOC && alloc_rsp.done) begin
      bmem[bind_cnt_r[BA_W-1:0]] <= '{key: key, map: {bdest_r, alloc_rsp.port}};
    end
    bmem_q <= bmem[bi_r[BA_W-1:0]];
  end

  // Build the result
  always_ff @(posedge clk) begin
    case (state_r)
      T_IDLE: begin
        res_status_r <= (in_tuser[1:0] == CMD_XLAT || in_tuser[1:0] == CMD_ADD ||
                         in_tuser[1:0] == CMD_DEL) ? ST_EXIST : ST_NORULE;
        res_addr_r   <= 32'd0;
        res_port_r   <= 16'd0;
      end
      T_BSCAN: begin
        if (b_hit) begin
          res_status_r <= ST_EXIST;
          res_addr_r   <= bmem_q.map[47:16];
          res_port_r   <= bmem_q.map[15:0];
        end
      end
      T_RSCAN: begin
        if (r_end) begin
          if (!found_r) res_status_r <= (cmd_r == CMD_DEL) ? ST_NOTAG : ST_NORULE;
          else if (cmd_r != CMD_DEL && bind_cnt_r >= BC_W'(BINDING_SLOTS))
            res_status_r <= ST_FULL;
        end
      end
      T_ALLOC: begin
        if (alloc_rsp.done) begin
          res_status_r <= ST_NEW;
          res_addr_r   <= bdest_r;
          res_port_r   <= alloc_rsp.port;
        end
      end
      T_ADD: begin
        if (lo_r > hi_r) res_status_r <= ST_RANGE;
        else if (!free_any) res_status_r <= ST_FULL;
      end
      default: ;
    endcase
  end

  // Output register: load a finished result, else drop the one taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == T_FIN && (!out_valid_r || out_tready)) begin
      out_valid_r  <= 1'b1;
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_port_r   <= res_port_r;
    end else if (out_valid_r && out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  a_bind_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bind_cnt_r <= BC_W'(BINDING_SLOTS))
    else $error("binding count beyond table size");

  a_alloc_done_in_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_rsp.done |-> state_r == T_ALLOC)
    else $error("port allocator finished outside an allocation");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != T_IDLE)
    else $error("accepted request did not start");

  a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_FIN && !out_valid_r) |=> out_valid_r)
    else $error("finished request not presented");

endmodule
